// ===== rtl/core/minv_pkg.sv =====
// Shared types, widths and helpers for the 3x3 matrix inverse block.
`default_nettype none
package minv_pkg;

    localparam int W           = 32;   // Q16.16 entry width
    localparam int PW          = 64;   // 32x32 product width
    localparam int CW          = 65;   // cofactor width (Q33.32, signed)
    localparam int AW          = 64;   // cofactor magnitude width
    localparam int DW          = 98;   // determinant width (Q50.48, signed)
    localparam int DMW         = 97;   // determinant magnitude width
    localparam int N_ENT       = 9;
    localparam int DIV_STEPS   = 32;   // one quotient bit per stage
    localparam int FRONT_STGS  = 7;
    localparam int N_STAGES    = FRONT_STGS + DIV_STEPS + 1;

    localparam logic [W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic signed [W-1:0] m00;
        logic signed [W-1:0] m01;
        logic signed [W-1:0] m02;
        logic signed [W-1:0] m10;
        logic signed [W-1:0] m11;
        logic signed [W-1:0] m12;
        logic signed [W-1:0] m20;
        logic signed [W-1:0] m21;
        logic signed [W-1:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [W-1:0] r00;
        logic signed [W-1:0] r01;
        logic signed [W-1:0] r02;
        logic signed [W-1:0] r10;
        logic signed [W-1:0] r11;
        logic signed [W-1:0] r12;
        logic signed [W-1:0] r20;
        logic signed [W-1:0] r21;
        logic signed [W-1:0] r22;
        logic signed [W-1:0] determinant;
        logic                singular;
    } t_res;

    typedef struct packed {
        logic neg;
        logic ovf;
    } t_lane_flags;

    typedef struct packed {
        logic [N_ENT-1:0][AW-1:0] am;      // adjugate magnitudes, row-major
        t_lane_flags [N_ENT-1:0]  flags;
        logic [DMW-1:0]           dmag;
        logic [W-1:0]             det_out;
        logic                     singular;
    } t_front;

    // Row or column kept when row/column idx is struck out.
    function automatic int keep_idx(input int idx, input int sel);
        int r;
        begin
            case (idx)
                0:       r = (sel != 0) ? 2 : 1;
                1:       r = (sel != 0) ? 2 : 0;
                default: r = (sel != 0) ? 1 : 0;
            endcase
            return r;
        end
    endfunction

    // Saturate a 32-bit quotient magnitude with sign into Q16.16.
    function automatic logic [W-1:0] sat_q(input logic [W-1:0] q, input logic neg,
                                           input logic ovf);
        logic [W-1:0] r;
        begin
            if (neg) begin
                r = (ovf || q > SAT_NEG) ? SAT_NEG : (~q + 32'd1);
            end else begin
                r = (ovf || q[W-1]) ? SAT_POS : q;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/minv_if.sv =====
// Valid/ready channel interfaces for the matrix input and the result output.
`default_nettype none
interface minv_in_if;
    logic              valid;
    logic              ready;
    minv_pkg::t_mat    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface minv_out_if;
    logic              valid;
    logic              ready;
    minv_pkg::t_res    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/minv_front.sv =====
// Front pipeline: cofactors, determinant, adjugate magnitudes and overflow flags.
`default_nettype none
module minv_front (
    input  wire logic                                 i_clk,
    input  wire logic [minv_pkg::FRONT_STGS-1:0]      i_en,
    input  wire minv_pkg::t_mat                       i_mat,
    output minv_pkg::t_front                          o_front
);
    localparam int W   = minv_pkg::W;
    localparam int PW  = minv_pkg::PW;
    localparam int CW  = minv_pkg::CW;
    localparam int AW  = minv_pkg::AW;
    localparam int DW  = minv_pkg::DW;
    localparam int DMW = minv_pkg::DMW;
    localparam int N   = minv_pkg::N_ENT;

    logic signed [W-1:0]  w_m [N];
    logic signed [PW-1:0] r1_pa [N];
    logic signed [PW-1:0] r1_pb [N];
    logic signed [W-1:0]  r1_m0 [3];
    logic signed [CW-1:0] r2_cof [N];
    logic signed [W-1:0]  r2_m0 [3];
    logic signed [CW-1:0] r3_cof [N];
    logic signed [CW-1:0] r3_plo [3];
    logic signed [CW-1:0] r3_phi [3];
    logic signed [CW-1:0] r4_cof [N];
    logic signed [DW-1:0] r4_term [3];
    logic signed [CW-1:0] r5_cof [N];
    logic signed [DW-1:0] r5_det;
    logic [AW-1:0]        r6_am [N];
    logic [N-1:0]         r6_neg;
    logic [DMW-1:0]       r6_dmag;
    logic                 r6_zero;
    logic                 r6_dneg;
    minv_pkg::t_front     r7_front;

    assign w_m[0] = i_mat.m00;
    assign w_m[1] = i_mat.m01;
    assign w_m[2] = i_mat.m02;
    assign w_m[3] = i_mat.m10;
    assign w_m[4] = i_mat.m11;
    assign w_m[5] = i_mat.m12;
    assign w_m[6] = i_mat.m20;
    assign w_m[7] = i_mat.m21;
    assign w_m[8] = i_mat.m22;

    genvar gi, gj;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_row
            for (gj = 0; gj < 3; gj++) begin : g_col
                localparam int R0 = minv_pkg::keep_idx(gi, 0);
                localparam int R1 = minv_pkg::keep_idx(gi, 1);
                localparam int C0 = minv_pkg::keep_idx(gj, 0);
                localparam int C1 = minv_pkg::keep_idx(gj, 1);
                localparam int K  = 3 * gi + gj;
                localparam bit ODD = ((gi + gj) % 2) != 0;
                logic signed [CW-1:0] w_diff;

                assign w_diff = {r1_pa[K][PW-1], r1_pa[K]} - {r1_pb[K][PW-1], r1_pb[K]};

                always_ff @(posedge i_clk) begin
                    if (i_en[0]) begin
                        r1_pa[K] <= w_m[3*R0+C0] * w_m[3*R1+C1];
                        r1_pb[K] <= w_m[3*R0+C1] * w_m[3*R1+C0];
                    end
                    if (i_en[1]) begin
                        r2_cof[K] <= ODD ? -w_diff : w_diff;
                    end
                end
            end
        end

        for (gj = 0; gj < 3; gj++) begin : g_det
            logic [W-1:0]          w_cl;
            logic signed [CW-W-1:0] w_ch;
            assign w_cl = r2_cof[gj][W-1:0];
            assign w_ch = r2_cof[gj][CW-1:W];

            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r1_m0[gj] <= w_m[gj];
                end
                if (i_en[1]) begin
                    r2_m0[gj] <= r1_m0[gj];
                end
                if (i_en[2]) begin
                    r3_plo[gj] <= r2_m0[gj] * $signed({1'b0, w_cl});
                    r3_phi[gj] <= r2_m0[gj] * w_ch;
                end
                if (i_en[3]) begin
                    r4_term[gj] <= {r3_phi[gj][CW-1], r3_phi[gj], {W{1'b0}}}
                                 + {{(DW-CW){r3_plo[gj][CW-1]}}, r3_plo[gj]};
                end
            end
        end
    endgenerate

    // Transposed adjugate magnitudes and signs, determinant magnitude.
    logic [CW-1:0] w_adj [N];
    logic [DW-1:0] w_dabs;
    assign w_dabs = r5_det[DW-1] ? -r5_det : r5_det;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_adj[k] = r5_cof[3 * (k % 3) + (k / 3)];
        end
    end

    logic [DMW-W-1:0] w_dt;   // determinant magnitude in Q16.16 units
    assign w_dt = r6_dmag[DMW-1:W];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_cof <= r2_cof;
        end
        if (i_en[3]) begin
            r4_cof <= r3_cof;
        end
        if (i_en[4]) begin
            r5_cof <= r4_cof;
            r5_det <= r4_term[0] + r4_term[1] + r4_term[2];
        end
        if (i_en[5]) begin
            for (int k = 0; k < N; k++) begin
                r6_am[k]  <= w_adj[k][CW-1] ? AW'(-w_adj[k]) : w_adj[k][AW-1:0];
                r6_neg[k] <= w_adj[k][CW-1] ^ r5_det[DW-1];
            end
            r6_dmag <= w_dabs[DMW-1:0];
            r6_zero <= (r5_det == '0);
            r6_dneg <= r5_det[DW-1];
        end
        if (i_en[6]) begin
            for (int k = 0; k < N; k++) begin
                r7_front.am[k]        <= r6_am[k];
                r7_front.flags[k].neg <= r6_neg[k];
                r7_front.flags[k].ovf <= {{(DMW-AW){1'b0}}, r6_am[k]} >= r6_dmag;
            end
            r7_front.dmag     <= r6_dmag;
            r7_front.singular <= r6_zero;
            // saturate the truncated determinant into Q16.16
            if (w_dt > {{(DMW-2*W){1'b0}}, minv_pkg::SAT_POS} && !r6_dneg) begin
                r7_front.det_out <= minv_pkg::SAT_POS;
            end else if (w_dt > {{(DMW-2*W){1'b0}}, minv_pkg::SAT_NEG} && r6_dneg) begin
                r7_front.det_out <= minv_pkg::SAT_NEG;
            end else if (r6_dneg) begin
                r7_front.det_out <= ~w_dt[W-1:0] + 32'd1;
            end else begin
                r7_front.det_out <= w_dt[W-1:0];
            end
        end
    end

    assign o_front = r7_front;

endmodule
`default_nettype wire

// ===== rtl/core/minv_div_lane.sv =====
// One divider lane: 32 restoring stages, one quotient bit per stage.
`default_nettype none
module minv_div_lane (
    input  wire logic                                                   i_clk,
    input  wire logic [minv_pkg::DIV_STEPS-1:0]                         i_en,
    input  wire logic [minv_pkg::DIV_STEPS-1:0][minv_pkg::DMW-1:0]      i_dmag,
    input  wire logic [minv_pkg::AW-1:0]                                i_rem,
    input  minv_pkg::t_lane_flags                                       i_flags,
    output logic [minv_pkg::W-1:0]                                      o_q,
    output minv_pkg::t_lane_flags                                       o_flags
);
    localparam int W   = minv_pkg::W;
    localparam int AW  = minv_pkg::AW;
    localparam int DMW = minv_pkg::DMW;
    localparam int S   = minv_pkg::DIV_STEPS;

    logic [DMW-1:0]        r_rem [S];
    logic [W-1:0]          r_q   [S];
    minv_pkg::t_lane_flags r_fl  [S];

    genvar gs;
    generate
        for (gs = 0; gs < S; gs++) begin : g_stage
            logic [DMW-1:0]        w_prev;
            logic [W-1:0]          w_pq;
            minv_pkg::t_lane_flags w_pfl;
            logic [DMW:0]          w_sh;
            logic [DMW:0]          w_sub;
            logic                  w_ge;

            if (gs == 0) begin : g_first
                assign w_prev = {{(DMW-AW){1'b0}}, i_rem};
                assign w_pq   = '0;
                assign w_pfl  = i_flags;
            end else begin : g_next
                assign w_prev = r_rem[gs-1];
                assign w_pq   = r_q[gs-1];
                assign w_pfl  = r_fl[gs-1];
            end

            assign w_sh  = {w_prev, 1'b0};
            assign w_sub = w_sh - {1'b0, i_dmag[gs]};
            assign w_ge  = (w_sh >= {1'b0, i_dmag[gs]});

            always_ff @(posedge i_clk) begin
                if (i_en[gs]) begin
                    r_rem[gs] <= w_ge ? w_sub[DMW-1:0] : w_sh[DMW-1:0];
                    r_q[gs]   <= {w_pq[W-2:0], w_ge};
                    r_fl[gs]  <= w_pfl;
                end
            end
        end
    endgenerate

    assign o_q     = r_q[S-1];
    assign o_flags = r_fl[S-1];

endmodule
`default_nettype wire

// ===== rtl/core/matrix3x3_inverse_top.sv =====
// Top level of the 3x3 matrix inverse: pipeline control, nine divider lanes, result merge.
//
// Usage:
//   i_in carries one 3x3 Q16.16 matrix per transaction (valid/ready). o_out carries
//   the inverse (r00..r22), the saturated determinant and the singular flag.
//   A transaction is taken at a rising edge with valid and ready both high.
//   Throughput: one matrix per cycle while o_out.ready stays high.
//   The depth is set by seven front stages (products, cofactors, two-part
//   determinant multiply and sums, magnitudes) and the 32 restoring-division
//   stages that each of the nine lanes runs, one quotient bit per stage.
//   Each stage holds its item until the next stage can take it, so bubbles
//   close up; when o_out.ready stays low the pipe fills and i_in.ready drops.
//   Synchronous active-low reset empties the pipe; payload is not cleared.
`default_nettype none
module matrix3x3_inverse_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    minv_in_if.sink    i_in,
    minv_out_if.source o_out
);
    localparam int W   = minv_pkg::W;
    localparam int DMW = minv_pkg::DMW;
    localparam int N   = minv_pkg::N_ENT;
    localparam int S   = minv_pkg::DIV_STEPS;
    localparam int F   = minv_pkg::FRONT_STGS;
    localparam int NS  = minv_pkg::N_STAGES;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    // Ready ripples back: a stage loads when it is empty or its successor loads.
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? i_in.valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    minv_pkg::t_front w_front;

    minv_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en[F-1:0]),
        .i_mat   (i_in.data),
        .o_front (w_front)
    );

    // Divisor and side-band results travel beside the lanes.
    logic [S-1:0][DMW-1:0] w_dsel;
    logic [DMW-1:0]        r_dmag [S];
    logic [W-1:0]          r_dout [S];
    logic                  r_sing [S];

    always_comb begin
        w_dsel[0] = w_front.dmag;
        for (int s = 1; s < S; s++) begin
            w_dsel[s] = r_dmag[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < S; s++) begin
            if (w_en[F+s]) begin
                r_dmag[s] <= w_dsel[s];
                r_dout[s] <= (s == 0) ? w_front.det_out  : r_dout[(s == 0) ? 0 : s - 1];
                r_sing[s] <= (s == 0) ? w_front.singular : r_sing[(s == 0) ? 0 : s - 1];
            end
        end
    end

    logic [W-1:0]          w_q  [N];
    minv_pkg::t_lane_flags w_fl [N];

    genvar gl;
    generate
        for (gl = 0; gl < N; gl++) begin : g_lane
            minv_div_lane u_lane (
                .i_clk   (i_clk),
                .i_en    (w_en[F+S-1:F]),
                .i_dmag  (w_dsel),
                .i_rem   (w_front.am[gl]),
                .i_flags (w_front.flags[gl]),
                .o_q     (w_q[gl]),
                .o_flags (w_fl[gl])
            );
        end
    endgenerate

    // Merge: saturate each lane, force zeros for a singular matrix.
    logic [W-1:0] w_r [N];
    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_r[k] = r_sing[S-1] ? '0 : minv_pkg::sat_q(w_q[k], w_fl[k].neg, w_fl[k].ovf);
        end
    end

    minv_pkg::t_res r_res;
    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_res.r00         <= w_r[0];
            r_res.r01         <= w_r[1];
            r_res.r02         <= w_r[2];
            r_res.r10         <= w_r[3];
            r_res.r11         <= w_r[4];
            r_res.r12         <= w_r[5];
            r_res.r20         <= w_r[6];
            r_res.r21         <= w_r[7];
            r_res.r22         <= w_r[8];
            r_res.determinant <= r_sing[S-1] ? '0 : r_dout[S-1];
            r_res.singular    <= r_sing[S-1];
        end
    end

    assign o_out.valid = r_v[NS-1];
    assign o_out.data  = r_res;

endmodule
`default_nettype wire

// ===== rtl/core/minv_checker.sv =====
// Port-level checks for the 3x3 matrix inverse, bound to the top level.
`default_nettype none
module minv_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire minv_pkg::t_res i_out_data
);
    // A result held back by the receiver stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // A singular matrix reports a zero determinant.
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.singular |-> i_out_data.determinant == '0)
        else $error("singular result with nonzero determinant");

    // A singular matrix yields an all-zero inverse.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.singular |->
            (i_out_data.r00 == '0) && (i_out_data.r01 == '0) && (i_out_data.r02 == '0) &&
            (i_out_data.r10 == '0) && (i_out_data.r11 == '0) && (i_out_data.r12 == '0) &&
            (i_out_data.r20 == '0) && (i_out_data.r21 == '0) && (i_out_data.r22 == '0))
        else $error("singular result with nonzero entries");

endmodule

bind matrix3x3_inverse_top minv_checker u_minv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire

// ===== dv/matrix3x3_inverse_sb.sv =====
// Scoreboard for the matrix inverse: exact Q16.16 inverse predictor and result queue.
`timescale 1ns / 100ps
`default_nettype none
class minv_scoreboard;
    minv_pkg::t_res pending_inverses[$];
    int unsigned    mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    // Saturate a signed quotient into Q16.16.
    static function logic signed [31:0] clamp_q16(logic signed [129:0] v);
        logic signed [31:0] r;
        if (v > 130'sd2147483647) r = 32'sh7FFF_FFFF;
        else if (v < -130'sd2147483648) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // Signed division truncating toward zero on magnitudes.
    static function logic signed [129:0] div_trunc(logic signed [129:0] n,
                                                   logic signed [129:0] d);
        logic [129:0] nm;
        logic [129:0] dm;
        logic [129:0] q;
        nm = n[129] ? -n : n;
        dm = d[129] ? -d : d;
        q  = nm / dm;
        return (n[129] != d[129]) ? -$signed(q) : $signed(q);
    endfunction

    function minv_pkg::t_res invert(minv_pkg::t_mat m);
        logic signed [129:0] e[9];
        logic signed [129:0] cof[3][3];
        logic signed [129:0] det;
        logic signed [129:0] one_q32;
        minv_pkg::t_res r;
        int ra, rb, ca, cb;
        e[0] = m.m00; e[1] = m.m01; e[2] = m.m02;
        e[3] = m.m10; e[4] = m.m11; e[5] = m.m12;
        e[6] = m.m20; e[7] = m.m21; e[8] = m.m22;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ra = (i == 0) ? 1 : 0; rb = (i == 2) ? 1 : 2;
                ca = (j == 0) ? 1 : 0; cb = (j == 2) ? 1 : 2;
                cof[i][j] = e[3*ra+ca] * e[3*rb+cb] - e[3*ra+cb] * e[3*rb+ca];
                if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
            end
        end
        det = e[0] * cof[0][0] + e[1] * cof[0][1] + e[2] * cof[0][2];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        one_q32 = 130'sd1 <<< 32;
        r.r00 = clamp_q16(div_trunc(cof[0][0] <<< 32, det));
        r.r01 = clamp_q16(div_trunc(cof[1][0] <<< 32, det));
        r.r02 = clamp_q16(div_trunc(cof[2][0] <<< 32, det));
        r.r10 = clamp_q16(div_trunc(cof[0][1] <<< 32, det));
        r.r11 = clamp_q16(div_trunc(cof[1][1] <<< 32, det));
        r.r12 = clamp_q16(div_trunc(cof[2][1] <<< 32, det));
        r.r20 = clamp_q16(div_trunc(cof[0][2] <<< 32, det));
        r.r21 = clamp_q16(div_trunc(cof[1][2] <<< 32, det));
        r.r22 = clamp_q16(div_trunc(cof[2][2] <<< 32, det));
        r.determinant = clamp_q16(div_trunc(det, one_q32));
        return r;
    endfunction

    function void note_matrix(minv_pkg::t_mat m);
        pending_inverses.push_back(invert(m));
    endfunction

    function void check_result(minv_pkg::t_res got);
        minv_pkg::t_res want;
        if (pending_inverses.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            mismatch_count++;
            return;
        end
        want = pending_inverses.pop_front();
        if (got.r00 !== want.r00) report("r00", want.r00, got.r00);
        if (got.r01 !== want.r01) report("r01", want.r01, got.r01);
        if (got.r02 !== want.r02) report("r02", want.r02, got.r02);
        if (got.r10 !== want.r10) report("r10", want.r10, got.r10);
        if (got.r11 !== want.r11) report("r11", want.r11, got.r11);
        if (got.r12 !== want.r12) report("r12", want.r12, got.r12);
        if (got.r20 !== want.r20) report("r20", want.r20, got.r20);
        if (got.r21 !== want.r21) report("r21", want.r21, got.r21);
        if (got.r22 !== want.r22) report("r22", want.r22, got.r22);
        if (got.determinant !== want.determinant)
            report("determinant", want.determinant, got.determinant);
        if (got.singular !== want.singular)
            report("singular", {31'b0, want.singular}, {31'b0, got.singular});
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %h actual %h", $realtime, field, want, got);
        mismatch_count++;
    endfunction
endclass
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top: drives matrices into the inverse block and checks every result.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int RANDOM_MATRICES = 1430;
    localparam int IDLE_LIMIT      = 5000;
    localparam int LATENCY         = 40;

    logic i_clk;
    logic i_rst_n;
    minv_in_if  in_ch();
    minv_out_if out_ch();

    matrix3x3_inverse_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    minv_scoreboard inverses = new();
    minv_pkg::t_mat matrix_list[$];
    bit   feeding_done;
    bit   hold_off_req;
    int   idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [31:0] pick_entry(int mode);
        logic [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $urandom_range(8, 0) << 16;      // small integers
            2: v = -($urandom_range(8, 0) << 16);
            3: v = $signed($urandom_range(512)) - 256;  // tiny fractions
            4: v = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
        return v;
    endfunction

    function automatic minv_pkg::t_mat diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        minv_pkg::t_mat m;
        m = '0;
        m.m00 = a; m.m11 = b; m.m22 = c;
        return m;
    endfunction

    task automatic build_directed();
        minv_pkg::t_mat m;
        matrix_list.push_back('0);                                 // all zero, singular
        matrix_list.push_back(diag(32'h1_0000, 32'h1_0000, 32'h1_0000));
        matrix_list.push_back(diag(32'hFFFF_0000, 32'h2_0000, 32'h0000_8000));
        matrix_list.push_back(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        matrix_list.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        matrix_list.push_back(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        matrix_list.push_back(diag(32'd1, 32'd1, 32'd1));         // tiny determinant
        matrix_list.push_back(diag(32'd1, 32'h1_0000, 32'h1_0000));
        matrix_list.push_back(diag(32'hFFFF_FFFF, 32'd2, 32'h1_0000));
        m = '1;                                                    // all -1 ulp, singular
        matrix_list.push_back(m);
        m = {9{32'h8000_0000}};
        matrix_list.push_back(m);
        m = {9{32'h7FFF_FFFF}};
        matrix_list.push_back(m);
        // rows equal: singular with nonzero entries
        m = '0;
        m.m00 = 32'h1_0000; m.m01 = 32'h2_0000; m.m02 = 32'h3_0000;
        m.m10 = 32'h1_0000; m.m11 = 32'h2_0000; m.m12 = 32'h3_0000;
        m.m20 = 32'h5_0000; m.m21 = 32'h7FFF_FFFF; m.m22 = 32'h8000_0000;
        matrix_list.push_back(m);
        // signed permutation matrix
        m = '0;
        m.m01 = 32'h1_0000; m.m12 = 32'hFFFF_0000; m.m20 = 32'h1_0000;
        matrix_list.push_back(m);
        // alternating extremes
        m = {32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
             32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        matrix_list.push_back(m);
        m = {32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555,
             32'h0, 32'h0, 32'h0, 32'h1_0000};
        matrix_list.push_back(m);
    endtask

    function automatic minv_pkg::t_mat random_matrix();
        minv_pkg::t_mat m;
        int mode;
        mode = $urandom_range(5);
        for (int k = 0; k < 9; k++)
            m[k*32 +: 32] = pick_entry(($urandom_range(3) == 0) ? $urandom_range(5) : mode);
        if ($urandom_range(19) == 0) begin
            m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;   // force singular
        end
        return m;
    endfunction

    task automatic send_matrix(minv_pkg::t_mat m);
        in_ch.valid <= 1'b1;
        in_ch.data  <= m;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        inverses.note_matrix(m);
        @(negedge i_clk);
    endtask

    task automatic feed_matrices();
        int n;
        foreach (matrix_list[k]) send_matrix(matrix_list[k]);
        in_ch.valid <= 1'b0;
        // let the pipe drain completely before the random part
        while (inverses.pending_inverses.size() != 0) @(negedge i_clk);
        hold_off_req = 1'b1;
        for (int k = 0; k < RANDOM_MATRICES; k++) begin
            if (k == 60) hold_off_req = 1'b0;
            if (k > 60) begin
                n = gap_len();
                if (n != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (n) @(negedge i_clk);
                end
            end
            send_matrix(random_matrix());
        end
        in_ch.valid <= 1'b0;
        feeding_done = 1'b1;
    endtask

    task automatic drain_results();
        int n;
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (120) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            n = gap_len();
            out_ch.ready <= (n == 0);
            if (n != 0) begin
                repeat (n) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) inverses.check_result(out_ch.data);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        feeding_done = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        i_rst_n      = 1'b0;
        build_directed();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        fork
            feed_matrices();
            drain_results();
        join_none
        wait (feeding_done);
        while (inverses.pending_inverses.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (inverses.mismatch_count == 0)
            $display("matrix3x3_inverse_top verification clean");
        else
            $display("matrix3x3_inverse_top verification failed");
        $finish;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("matrix3x3_inverse_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire
